@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the filter core modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check with an explicit clock and active-low reset
`define FTD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: check failed");

// Same check on the standard clk_i / rst_ni pair
`define FTD_ASSERT_STD(lbl, prop) `FTD_ASSERT(lbl, clk_i, rst_ni, prop)

`endif

@@ rtl/core/ftd_pkg.sv @@
// Shared constants and types of the nine-tap filter with level detector
`timescale 1ns / 1ps
package ftd_pkg;

  localparam int unsigned TAP_COUNT = 9;
  localparam int unsigned SUM_W     = 25;
  localparam int unsigned LEVEL_W   = 25;
  localparam int unsigned HIT_W     = 32;
  localparam int unsigned WEIGHT_W  = 16;
  localparam int unsigned FILL_W    = 4;

  localparam logic [LEVEL_W-1:0] LEVEL_RESET = 25'd10000000;
  localparam logic [FILL_W-1:0]  FILL_FULL   = FILL_W'(TAP_COUNT);

  // index 0 weighs the newest sample
  localparam logic [WEIGHT_W-1:0] TAP_WEIGHT [TAP_COUNT] = '{
    16'd12, 16'd866, 16'd7802, 16'd24130, 16'd34375,
    16'd24130, 16'd7802, 16'd866, 16'd25
  };

  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] sum;
  } ftd_sum_t;

endpackage

@@ rtl/core/ftd_tap_cell.sv @@
// One tap of the transposed filter: constant multiply plus partial sum register
`timescale 1ns / 1ps
module ftd_tap_cell import ftd_pkg::*; #(
  parameter int unsigned          SAMPLE_BITS = 8,
  parameter logic [WEIGHT_W-1:0]  WEIGHT      = 16'd12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic [SUM_W-1:0]       psum_i,
  output logic [SUM_W-1:0]       psum_o
);

  localparam int unsigned PROD_W = SAMPLE_BITS + WEIGHT_W;

  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  psum_d, psum_q;

  assign prod   = {{WEIGHT_W{1'b0}}, sample_i} * {{SAMPLE_BITS{1'b0}}, WEIGHT};
  assign psum_d = psum_i + SUM_W'(prod);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      psum_q <= '0;
    end else if (en_i) begin
      psum_q <= psum_d;
    end
  end

  assign psum_o = psum_q;

endmodule

@@ rtl/core/ftd_detect.sv @@
// Level compare, hit counter and output register
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ftd_detect import ftd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ftd_sum_t           sum_i,
  output logic               take_o,
  input  logic               cfg_valid_i,
  input  logic [LEVEL_W-1:0] cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [SUM_W-1:0]   filtered_o,
  output logic               above_o,
  output logic [HIT_W-1:0]   hit_count_o
);

  logic [LEVEL_W-1:0] level_q;
  logic               out_v_q;
  logic [SUM_W-1:0]   filt_q;
  logic               above_d, above_q;
  logic [HIT_W-1:0]   hit_d, hit_q;
  logic               load;

  assign take_o  = !out_v_q || !out_stall_i;
  assign load    = sum_i.valid && take_o;
  assign above_d = sum_i.sum >= level_q;
  assign hit_d   = hit_q + HIT_W'(above_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= LEVEL_RESET;
    end else if (cfg_valid_i) begin
      level_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      hit_q   <= '0;
    end else begin
      if (take_o) begin
        out_v_q <= sum_i.valid;
      end
      if (load) begin
        hit_q <= hit_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      filt_q  <= sum_i.sum;
      above_q <= above_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign filtered_o  = filt_q;
  assign above_o     = above_q;
  assign hit_count_o = hit_q;

  `FTD_ASSERT_STD(a_drain_empties, (out_valid_o && !out_stall_i && !sum_i.valid) |=> !out_valid_o)
  `FTD_ASSERT_STD(a_hits_only_on_load, !load |=> $stable(hit_count_o))
  `FTD_ASSERT_STD(a_hold_only_when_full, !take_o |-> out_valid_o)

endmodule

@@ rtl/core/fir9_threshold_detector_core.sv @@
// Top level: nine-tap transposed FIR chain with level detector and hit counter
// A sample's result passes the tap partial-sum registers, then the output register.
// Throughput: one sample per cycle while no sum waits on a stalled output register.
// The first nine samples after reset fill the chain and produce no result.
// Reset (async, active low) clears partial sums, fill count, hit count and valids,
// and sets the detect level to 10000000.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fir9_threshold_detector_core import ftd_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         sample_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [SUM_W-1:0]   filtered_o,
  output logic               above_o,
  output logic [HIT_W-1:0]   hit_count_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [LEVEL_W-1:0] cfg_data_i
);

  logic [SAMPLE_BITS-1:0] smp;
  logic                   in_acc;
  logic                   adv_a;
  logic                   take;
  logic                   a_v_q;
  logic [FILL_W-1:0]      fill_q;
  logic [SUM_W-1:0]       psum [TAP_COUNT+1];
  ftd_sum_t               sum;

  assign smp    = sample_i[SAMPLE_BITS-1:0];
  assign adv_a  = !a_v_q || take;
  assign in_stall_o  = !adv_a;
  assign in_acc = in_valid_i && adv_a;
  assign cfg_ready_o = 1'b1;

  assign psum[TAP_COUNT] = '0;

  for (genvar k = 0; k < TAP_COUNT; k++) begin : g_tap
    ftd_tap_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .WEIGHT      (TAP_WEIGHT[k])
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (in_acc),
      .sample_i (smp),
      .psum_i   (psum[k+1]),
      .psum_o   (psum[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      a_v_q  <= 1'b0;
    end else begin
      if (in_acc && fill_q != FILL_FULL) begin
        fill_q <= fill_q + 1'b1;
      end
      if (adv_a) begin
        a_v_q <= in_acc && fill_q == FILL_FULL;
      end
    end
  end

  assign sum.valid = a_v_q;
  assign sum.sum   = psum[0];

  ftd_detect u_detect (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sum_i       (sum),
    .take_o      (take),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .filtered_o  (filtered_o),
    .above_o     (above_o),
    .hit_count_o (hit_count_o)
  );

  `FTD_ASSERT_STD(a_fill_bounded, fill_q <= FILL_FULL)
  `FTD_ASSERT_STD(a_stall_only_when_full, in_stall_o |-> (a_v_q && out_valid_o && out_stall_i))
  `FTD_ASSERT_STD(a_no_result_while_filling, (in_acc && fill_q != FILL_FULL) |=> !a_v_q)

endmodule
